// ===== design/utf8_to_utf16_decoder_unit_macros.svh =====
// Assertion macros shared by the checkers of the UTF-8 to UTF-16 decoder.
// No dependencies; take in with a bare include.
`ifndef UTF8_TO_UTF16_DECODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define U8U16_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("u8u16 checker: property violated");

// cons must hold in the same cycle as ante
`define U8U16_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u8u16 checker: property violated");

// cons must hold in the cycle after ante
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u8u16 checker: property violated");

`endif

// ===== design/u8u16_pkg.sv =====
// Types, constants and register codes of the UTF-8 to UTF-16 decoder.
// No dependencies; used by the cfg register, decode, result register and top-level files.
package u8u16_pkg;

	localparam int CountW     = 17;
	localparam int UnitW      = 16;
	localparam int CfgIdxW    = 2;
	localparam int MaxResults = 3;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_LF_CONVERT   = 2'd0,
		CFG_ERROR_CHECK  = 2'd1,
		CFG_OUT_CAPACITY = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              lf_convert;
		logic              error_check;
		logic [CountW-1:0] out_capacity;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [UnitW-1:0]  code_unit;
		logic              unit_valid;
		logic              string_done;
		logic              error_flag;
		logic [CountW-1:0] unit_count;
	} result_t;

	// results of one input item, in order, with their number
	typedef struct packed {
		result_t [MaxResults-1:0] res;
		logic [1:0]               cnt;
	} res_bundle_t;

	// per-string decoder state
	typedef struct packed {
		logic [23:0]       held;
		logic [1:0]        need;
		logic [1:0]        hcnt;
		logic              prev_cr;
		logic [CountW-1:0] units;
		logic              failed;
		logic              closed;
	} dec_state_t;

	localparam logic [7:0]       ByteLf     = 8'h0A;
	localparam logic [7:0]       ByteCr     = 8'h0D;
	localparam logic [UnitW-1:0] SurrHiBase = 16'hD800;
	localparam logic [UnitW-1:0] SurrLoBase = 16'hDC00;
	localparam logic [UnitW-1:0] SurrOffset = 16'h0040;

endpackage

// ===== design/u8u16_in_if.sv =====
// Byte input channel of the decoder: valid/ready plus one UTF-8 byte item.
// No dependencies.
interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;

	modport source (output valid, data_byte, byte_valid, last, input ready);
	modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

// ===== design/u8u16_out_if.sv =====
// Result channel of the decoder: valid/ready plus one UTF-16 result item.
// No dependencies.
interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        unit_valid;
	logic        string_done;
	logic        error_flag;
	logic [16:0] unit_count;
	logic        last_result;

	modport source (output valid, code_unit, unit_valid, string_done, error_flag,
		unit_count, last_result, input ready);
	modport sink (input valid, code_unit, unit_valid, string_done, error_flag,
		unit_count, last_result, output ready);
endinterface

// ===== design/u8u16_cfg_if.sv =====
// Configuration write channel of the decoder: register index and write data.
// No dependencies.
interface u8u16_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [16:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== design/u8u16_cfg_regs.sv =====
// Configuration registers of the decoder.
// Depends on u8u16_pkg.
module u8u16_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [u8u16_pkg::CfgIdxW-1:0]        wr_index,
	input  logic [u8u16_pkg::CountW-1:0]         wr_data,
	output u8u16_pkg::cfg_t                      cfg
);

	u8u16_pkg::cfg_t cfg_q;

	// register write; an unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lf_convert   <= 1'b0;
			cfg_q.error_check  <= 1'b0;
			cfg_q.out_capacity <= u8u16_pkg::CountMax;
		end else if (wr_en) begin
			unique case (wr_index)
				u8u16_pkg::CFG_LF_CONVERT:   cfg_q.lf_convert   <= wr_data[0];
				u8u16_pkg::CFG_ERROR_CHECK:  cfg_q.error_check  <= wr_data[0];
				u8u16_pkg::CFG_OUT_CAPACITY: cfg_q.out_capacity <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/u8u16_decode.sv =====
// Input register, string state and single-pass decode of one byte into up to
// three results. Depends on u8u16_pkg.
module u8u16_decode (
	input  logic                   clk,
	input  logic                   arst_n,
	input  u8u16_pkg::cfg_t        cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  u8u16_pkg::in_item_t    in_item,
	input  logic                   res_free,
	output logic                   res_load,
	output u8u16_pkg::res_bundle_t bundle
);

	logic                           valid_s1;
	u8u16_pkg::in_item_t            item_s1;
	u8u16_pkg::dec_state_t          st_q;
	u8u16_pkg::dec_state_t          st_nxt;
	logic                           do_consume;
	logic                           end_item;
	logic [1:0]                     u_cnt;
	logic [u8u16_pkg::UnitW-1:0]    u_code0;
	logic [u8u16_pkg::UnitW-1:0]    u_code1;
	logic [u8u16_pkg::UnitW-1:0]    surr_hi;
	logic [u8u16_pkg::CountW-1:0]   pos1;
	logic [u8u16_pkg::CountW-1:0]   pos2;
	logic [u8u16_pkg::CountW-1:0]   end_cnt;
	logic                           end_fail;
	logic [1:0]                     n_res;
	logic                           adv;
	u8u16_pkg::result_t             unit0;
	u8u16_pkg::result_t             unit1;
	u8u16_pkg::result_t             end_res;
	logic [7:0]                     b;
	logic [7:0]                     b0;
	logic [7:0]                     b1;
	logic [7:0]                     b2;

	function automatic logic [u8u16_pkg::CountW-1:0] sat_inc(
		input logic [u8u16_pkg::CountW-1:0] x);
		sat_inc = (x == u8u16_pkg::CountMax) ? x : x + {{(u8u16_pkg::CountW-1){1'b0}}, 1'b1};
	endfunction

	assign b  = item_s1.data_byte;
	assign b0 = st_q.held[7:0];
	assign b1 = st_q.held[15:8];
	assign b2 = st_q.held[23:16];

	// high surrogate from the held lead and first two continuation bytes
	assign surr_hi = (u8u16_pkg::SurrHiBase | {5'b0, b0[2:0], b1[5:0], b2[5:4]})
		- u8u16_pkg::SurrOffset;

	// next state and unit codes for the item in s1
	always_comb begin
		st_nxt  = st_q;
		u_cnt   = 2'd0;
		u_code0 = '0;
		u_code1 = '0;
		do_consume = valid_s1 && !st_q.closed && item_s1.byte_valid && !st_q.failed
			&& !(st_q.need == 2'd0 && b == 8'h00);
		end_item = valid_s1 && !st_q.closed && (item_s1.last || (item_s1.byte_valid
			&& !st_q.failed && st_q.need == 2'd0 && b == 8'h00));
		if (valid_s1 && st_q.closed && item_s1.last)
			st_nxt.closed = 1'b0;
		if (do_consume) begin
			if (st_q.need == 2'd0) begin
				priority if (!b[7]) begin
					if (cfg.lf_convert && b == u8u16_pkg::ByteLf && !st_q.prev_cr) begin
						u_cnt   = 2'd2;
						u_code0 = {8'h00, u8u16_pkg::ByteCr};
						u_code1 = {8'h00, b};
					end else begin
						u_cnt   = 2'd1;
						u_code0 = {8'h00, b};
					end
				end else if (b[7:3] == 5'b11111) begin
					st_nxt.failed = 1'b1;
				end else if (b[7:3] == 5'b11110) begin
					st_nxt.need = 2'd3;
					st_nxt.held = {16'h0000, b};
					st_nxt.hcnt = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					st_nxt.need = 2'd2;
					st_nxt.held = {16'h0000, b};
					st_nxt.hcnt = 2'd1;
				end else if (b[7:5] == 3'b110) begin
					st_nxt.need = 2'd1;
					st_nxt.held = {16'h0000, b};
					st_nxt.hcnt = 2'd1;
				end else begin
					// stray continuation byte
					st_nxt.failed = 1'b1;
				end
			end else if (cfg.error_check && !b[7]) begin
				st_nxt.failed = 1'b1;
				st_nxt.held   = '0;
				st_nxt.need   = 2'd0;
				st_nxt.hcnt   = 2'd0;
			end else if (st_q.need == 2'd1) begin
				unique case (st_q.hcnt)
					2'd1: begin
						u_cnt   = 2'd1;
						u_code0 = {5'b0, b0[4:0], b[5:0]};
					end
					2'd2: begin
						u_cnt   = 2'd1;
						u_code0 = {b0[3:0], b1[5:0], b[5:0]};
					end
					default: begin
						u_cnt   = 2'd2;
						u_code0 = surr_hi;
						u_code1 = u8u16_pkg::SurrLoBase | {6'b0, b2[3:0], b[5:0]};
					end
				endcase
				st_nxt.held = '0;
				st_nxt.need = 2'd0;
				st_nxt.hcnt = 2'd0;
			end else begin
				unique case (st_q.hcnt)
					2'd1:    st_nxt.held[15:8]  = b;
					2'd2:    st_nxt.held[23:16] = b;
					default: st_nxt.held[7:0]   = st_q.held[7:0] | b;
				endcase
				st_nxt.hcnt = st_q.hcnt + 2'd1;
				st_nxt.need = st_q.need - 2'd1;
			end
			st_nxt.prev_cr = (b == u8u16_pkg::ByteCr);
		end
		// unit positions and count after this item's units
		pos1 = sat_inc(st_q.units);
		pos2 = sat_inc(pos1);
		unique case (u_cnt)
			2'd1:    st_nxt.units = pos1;
			2'd2:    st_nxt.units = pos2;
			default: st_nxt.units = st_q.units;
		endcase
		end_fail = st_nxt.failed || (st_nxt.need != 2'd0 && cfg.error_check);
		end_cnt  = end_fail ? '0 : st_nxt.units;
		if (end_item) begin
			st_nxt.held    = '0;
			st_nxt.need    = 2'd0;
			st_nxt.hcnt    = 2'd0;
			st_nxt.prev_cr = 1'b0;
			st_nxt.units   = '0;
			st_nxt.failed  = 1'b0;
			st_nxt.closed  = !item_s1.last;
		end
	end

	// result records
	always_comb begin
		unit0             = '0;
		unit0.unit_valid  = st_q.units < cfg.out_capacity;
		unit0.code_unit   = unit0.unit_valid ? u_code0 : '0;
		unit1             = '0;
		unit1.unit_valid  = pos1 < cfg.out_capacity;
		unit1.code_unit   = unit1.unit_valid ? u_code1 : '0;
		end_res             = '0;
		end_res.unit_valid  = end_cnt < cfg.out_capacity;
		end_res.string_done = 1'b1;
		end_res.error_flag  = end_fail && cfg.error_check;
		end_res.unit_count  = end_cnt;
		bundle.res[0] = (u_cnt != 2'd0) ? unit0 : end_res;
		bundle.res[1] = (u_cnt == 2'd2) ? unit1 : end_res;
		bundle.res[2] = end_res;
		n_res      = u_cnt + {1'b0, end_item};
		bundle.cnt = n_res;
	end

	// s1 leaves when it has no results or the result register can take them
	assign adv      = valid_s1 && (n_res == 2'd0 || res_free);
	assign res_load = adv && n_res != 2'd0;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	// string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (adv)
			st_q <= st_nxt;
	end

endmodule

// ===== design/u8u16_out_buf.sv =====
// Result register: holds the results of one item and hands them out in order.
// Depends on u8u16_pkg.
module u8u16_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  u8u16_pkg::res_bundle_t bundle,
	output logic                   res_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output u8u16_pkg::result_t     out_res,
	output logic                   out_last
);

	u8u16_pkg::result_t [u8u16_pkg::MaxResults-1:0] res_s2;
	logic [1:0] cnt_s2;
	logic [1:0] idx_q;
	logic       valid_s2;
	logic       take;

	assign out_valid = valid_s2;
	assign out_res   = res_s2[idx_q];
	assign out_last  = idx_q == cnt_s2 - 2'd1;
	assign take      = valid_s2 && out_ready;
	assign res_free  = !valid_s2 || (take && out_last);

	// control: valid and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= 2'd0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			cnt_s2   <= bundle.cnt;
			idx_q    <= 2'd0;
		end else if (take) begin
			if (out_last)
				valid_s2 <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_s2 <= bundle.res;
	end

endmodule

// ===== design/utf8_to_utf16_decoder_unit.sv =====
// UTF-8 to UTF-16 decoder top level.
// Channels: byte_in takes one UTF-8 byte item (data_byte, byte_valid, last);
// unit_out gives result items (code_unit, unit_valid, string_done,
// error_flag, unit_count, last_result); cfg writes lf_convert (0),
// error_check (1) and out_capacity (2), always ready.
// The first result of an item passes the input register, then the result
// register, before it is offered; a busy result register holds it back.
// Throughput: one item per cycle while each item gives at most one result and
// the receiver is ready; an item with two or three results (CR insertion,
// surrogate pair, end of string) holds the result register until the single
// output port has handed out each of them. Items with no result never wait
// for the output. When the receiver stalls, results hold and the input
// register fills, after which byte_in.ready drops; nothing is lost.
// Reset clears the string state, the pipeline and the registers to their
// defaults (capacity 131071); no clearing pass is needed.
// Depends on u8u16_pkg, the channel interfaces and the submodules.
module utf8_to_utf16_decoder_unit (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_in_if.sink     byte_in,
	u8u16_out_if.source  unit_out,
	u8u16_cfg_if.sink    cfg
);

	u8u16_pkg::cfg_t        cfg_regs;
	u8u16_pkg::in_item_t    in_item;
	u8u16_pkg::res_bundle_t bundle;
	u8u16_pkg::result_t     out_res;
	logic                   res_free;
	logic                   res_load;
	logic                   out_last;

	assign cfg.ready          = 1'b1;
	assign in_item.data_byte  = byte_in.data_byte;
	assign in_item.byte_valid = byte_in.byte_valid;
	assign in_item.last       = byte_in.last;

	u8u16_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.reg_index),
		.wr_data  (cfg.wr_data),
		.cfg      (cfg_regs)
	);

	u8u16_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_regs),
		.in_valid (byte_in.valid),
		.in_ready (byte_in.ready),
		.in_item  (in_item),
		.res_free (res_free),
		.res_load (res_load),
		.bundle   (bundle)
	);

	u8u16_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.bundle    (bundle),
		.res_free  (res_free),
		.out_valid (unit_out.valid),
		.out_ready (unit_out.ready),
		.out_res   (out_res),
		.out_last  (out_last)
	);

	assign unit_out.code_unit   = out_res.code_unit;
	assign unit_out.unit_valid  = out_res.unit_valid;
	assign unit_out.string_done = out_res.string_done;
	assign unit_out.error_flag  = out_res.error_flag;
	assign unit_out.unit_count  = out_res.unit_count;
	assign unit_out.last_result = out_last;

endmodule

// ===== design/u8u16_checker.sv =====
// Port-level checker of the decoder, bound to the top level.
// Depends on utf8_to_utf16_decoder_unit_macros.svh.
`include "utf8_to_utf16_decoder_unit_macros.svh"

module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        unit_valid,
	input logic        string_done,
	input logic        error_flag,
	input logic [16:0] unit_count,
	input logic        last_result
);

	logic unit_clean;
	logic err_clean;

	// unit results carry no count and no error; dropped units read as zero
	assign unit_clean = !error_flag && unit_count == 17'd0
		&& (unit_valid || code_unit == 16'd0);
	// an error end reports zero units and a zero terminator
	assign err_clean = string_done && unit_count == 17'd0 && code_unit == 16'd0;

	// a stalled result item stays offered
	`U8U16_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// the end of a string is always the last result of its item
	`U8U16_ASSERT_IMPLIES(a_done_last, clk, arst_n, out_valid && string_done, last_result)

	`U8U16_ASSERT_IMPLIES(a_unit_clean, clk, arst_n, out_valid && !string_done, unit_clean)

	`U8U16_ASSERT_IMPLIES(a_err_end, clk, arst_n, out_valid && error_flag, err_clean)

endmodule

bind utf8_to_utf16_decoder_unit u8u16_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (unit_out.valid),
	.out_ready   (unit_out.ready),
	.code_unit   (unit_out.code_unit),
	.unit_valid  (unit_out.unit_valid),
	.string_done (unit_out.string_done),
	.error_flag  (unit_out.error_flag),
	.unit_count  (unit_out.unit_count),
	.last_result (unit_out.last_result)
);

// ===== verif/utf8_to_utf16_decoder_unit_tb.sv =====
// Self-checking testbench of the UTF-8 to UTF-16 decoder: directed strings, then random strings.
// Holds its own decoder model and checks every result item against it.
// Depends on u8u16_pkg, the three channel interfaces and utf8_to_utf16_decoder_unit.
module utf8_to_utf16_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected result item together with its last_result mark
	typedef struct packed {
		u8u16_pkg::result_t res;
		logic               last_result;
	} unit_rec_t;

	logic clk;
	logic arst_n;

	u8u16_in_if  byte_ch();
	u8u16_out_if unit_ch();
	u8u16_cfg_if cfg_ch();

	utf8_to_utf16_decoder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_ch),
		.unit_out (unit_ch),
		.cfg      (cfg_ch)
	);

	u8u16_pkg::in_item_t   pending_bytes[$];
	unit_rec_t             units_due[$];
	u8u16_pkg::result_t    item_units[$];
	u8u16_pkg::in_item_t   next_byte;
	u8u16_pkg::dec_state_t dec;
	u8u16_pkg::cfg_t       mode;

	int queued     = 0;
	int mismatches = 0;
	int in_gap     = 0;
	int out_stall  = 0;
	bit in_fire    = 1'b0;
	bit steady     = 1'b0;
	bit calm       = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// decoder model
	// ---------------------------------------------------------------

	function automatic void drop_seq();
		dec.held = '0;
		dec.need = '0;
		dec.hcnt = '0;
	endfunction

	// a unit at or past the capacity is counted but goes out as zero
	function automatic void emit_unit(logic [u8u16_pkg::UnitW-1:0] cu);
		u8u16_pkg::result_t r;
		r = '0;
		r.unit_valid = (dec.units < mode.out_capacity);
		if (r.unit_valid)
			r.code_unit = cu;
		item_units.push_back(r);
		if (dec.units != u8u16_pkg::CountMax)
			dec.units++;
	endfunction

	function automatic void fail_string();
		dec.failed = 1'b1;
		drop_seq();
	endfunction

	function automatic void take_byte(logic [7:0] b);
		logic [u8u16_pkg::UnitW-1:0] hi;
		if (dec.need == 0) begin
			// lead position
			if (!b[7]) begin
				if (mode.lf_convert && b == u8u16_pkg::ByteLf && !dec.prev_cr)
					emit_unit({8'h00, u8u16_pkg::ByteCr});
				emit_unit({8'h00, b});
			end else if (b[7:3] == 5'b11111) begin
				fail_string();
			end else if (b[7:3] == 5'b11110) begin
				dec.need = 2'd3;
			end else if (b[7:4] == 4'b1110) begin
				dec.need = 2'd2;
			end else if (b[7:5] == 3'b110) begin
				dec.need = 2'd1;
			end else begin
				fail_string();
			end
			if (dec.need != 0) begin
				dec.held = {16'h0000, b};
				dec.hcnt = 2'd1;
			end
		end else if (mode.error_check && !b[7]) begin
			fail_string();
		end else if (dec.need == 1) begin
			// final continuation: build the unit or the surrogate pair
			if (dec.hcnt == 2'd1) begin
				emit_unit({5'd0, dec.held[4:0], b[5:0]});
			end else if (dec.hcnt == 2'd2) begin
				emit_unit({dec.held[3:0], dec.held[13:8], b[5:0]});
			end else begin
				hi = (u8u16_pkg::SurrHiBase | {5'd0, dec.held[2:0], 8'd0}
					| {8'd0, dec.held[13:8], 2'd0} | {14'd0, dec.held[21:20]})
					- u8u16_pkg::SurrOffset;
				emit_unit(hi);
				emit_unit(u8u16_pkg::SurrLoBase | {6'd0, dec.held[19:16], b[5:0]});
			end
			drop_seq();
		end else begin
			dec.held = dec.held | (24'(b) << (8 * dec.hcnt));
			dec.hcnt++;
			dec.need--;
		end
		dec.prev_cr = (b == u8u16_pkg::ByteCr);
	endfunction

	// end of string: terminator with count or error indication
	function automatic void close_string();
		u8u16_pkg::result_t r;
		r = '0;
		if (dec.need != 0 && mode.error_check)
			dec.failed = 1'b1;
		r.string_done = 1'b1;
		if (dec.failed)
			r.error_flag = mode.error_check;
		else
			r.unit_count = dec.units;
		r.unit_valid = (r.unit_count < mode.out_capacity);
		item_units.push_back(r);
		drop_seq();
		dec.prev_cr = 1'b0;
		dec.units   = '0;
		dec.failed  = 1'b0;
	endfunction

	function automatic void decode_item(u8u16_pkg::in_item_t it);
		logic      stop;
		unit_rec_t rec;
		stop = it.last;
		item_units.delete();
		if (dec.closed) begin
			// after a zero byte end, skip up to the item marked last
			if (it.last)
				dec.closed = 1'b0;
			return;
		end
		if (it.byte_valid && !dec.failed) begin
			if (dec.need == 0 && it.data_byte == 8'h00)
				stop = 1'b1;
			else
				take_byte(it.data_byte);
		end
		if (stop) begin
			close_string();
			if (!it.last)
				dec.closed = 1'b1;
		end
		foreach (item_units[i]) begin
			rec.res = item_units[i];
			rec.last_result = (i == item_units.size() - 1);
			units_due.push_back(rec);
		end
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void put_item(logic [7:0] b, logic bv, logic lst);
		u8u16_pkg::in_item_t it;
		it.data_byte  = b;
		it.byte_valid = bv;
		it.last       = lst;
		pending_bytes.push_back(it);
		queued++;
	endfunction

	function automatic logic [7:0] rand_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// one string: mostly well-formed characters, some noise, then an end item
	function automatic void gen_string();
		int         r;
		logic [7:0] b;
		repeat ($urandom_range(1, 8)) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				b = 8'($urandom_range(1, 127));
				case ($urandom_range(0, 9))
					0: b = u8u16_pkg::ByteCr;
					1: b = u8u16_pkg::ByteLf;
					default: ;
				endcase
				put_item(b, 1'b1, 1'b0);
			end else if (r < 48) begin
				put_item(8'hC0 | 8'($urandom_range(0, 31)), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
			end else if (r < 62) begin
				put_item(8'hE0 | 8'($urandom_range(0, 15)), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
			end else if (r < 76) begin
				put_item(8'hF0 | 8'($urandom_range(0, 7)), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
			end else if (r < 82) begin
				put_item(u8u16_pkg::ByteCr, 1'b1, 1'b0);
				put_item(u8u16_pkg::ByteLf, 1'b1, 1'b0);
			end else if (r < 86) begin
				put_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
			end else if (r < 90) begin
				// three-byte sequence cut short
				put_item(8'hE0 | 8'($urandom_range(0, 15)), 1'b1, 1'b0);
				put_item(rand_cont(), 1'b1, 1'b0);
			end else if (r < 94) begin
				// continuation without its top bit
				put_item(8'hC0 | 8'($urandom_range(0, 31)), 1'b1, 1'b0);
				put_item(8'($urandom_range(0, 127)), 1'b1, 1'b0);
			end else if (r < 96) begin
				put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else if (r < 98) begin
				put_item(8'h00, 1'b1, 1'b0);
			end else begin
				put_item(8'hF8 | 8'($urandom_range(0, 7)), 1'b1, 1'b0);
			end
		end
		r = $urandom_range(0, 9);
		if (r < 4)
			put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		else if (r < 8)
			put_item(8'($urandom_range(0, 127)), 1'b1, 1'b1);
		else
			put_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
	endfunction

	task automatic write_reg(u8u16_pkg::cfg_idx_t idx, logic [u8u16_pkg::CountW-1:0] val);
		@(negedge clk);
		cfg_ch.valid     = 1'b1;
		cfg_ch.reg_index = idx;
		cfg_ch.wr_data   = val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (idx)
			u8u16_pkg::CFG_LF_CONVERT:   mode.lf_convert   = val[0];
			u8u16_pkg::CFG_ERROR_CHECK:  mode.error_check  = val[0];
			u8u16_pkg::CFG_OUT_CAPACITY: mode.out_capacity = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_mode(logic lf, logic chk, logic [u8u16_pkg::CountW-1:0] cap);
		write_reg(u8u16_pkg::CFG_LF_CONVERT, u8u16_pkg::CountW'(lf));
		write_reg(u8u16_pkg::CFG_ERROR_CHECK, u8u16_pkg::CountW'(chk));
		write_reg(u8u16_pkg::CFG_OUT_CAPACITY, cap);
	endtask

	// wait until every queued item is taken and every result has come back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || byte_ch.valid || units_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_phase(logic lf, logic chk, logic [u8u16_pkg::CountW-1:0] cap,
		int n);
		int start;
		set_mode(lf, chk, cap);
		start = queued;
		while (queued - start < n)
			gen_string();
		drain();
	endtask

	// ---------------------------------------------------------------
	// byte driver: holds an item until taken, random gaps between items
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (!byte_ch.valid || in_fire) begin
			if (in_gap > 0) begin
				byte_ch.valid <= 1'b0;
				in_gap = in_gap - 1;
			end else if (pending_bytes.size() != 0) begin
				next_byte = pending_bytes.pop_front();
				byte_ch.data_byte  <= next_byte.data_byte;
				byte_ch.byte_valid <= next_byte.byte_valid;
				byte_ch.last       <= next_byte.last;
				byte_ch.valid      <= 1'b1;
				in_gap = pick_gap();
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver back-pressure
	always @(negedge clk) begin
		if (out_stall > 0) begin
			unit_ch.ready <= 1'b0;
			out_stall = out_stall - 1;
		end else begin
			unit_ch.ready <= 1'b1;
			if (!steady && $urandom_range(0, 2) == 0)
				out_stall = pick_gap();
		end
	end

	// ---------------------------------------------------------------
	// monitor: predict on each taken byte item, check each result item
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		unit_rec_t got;
		in_fire = byte_ch.valid && byte_ch.ready;
		if (arst_n) begin
			if (in_fire)
				decode_item('{data_byte: byte_ch.data_byte, byte_valid: byte_ch.byte_valid,
					last: byte_ch.last});
			if (unit_ch.valid && unit_ch.ready) begin
				got.res.code_unit   = unit_ch.code_unit;
				got.res.unit_valid  = unit_ch.unit_valid;
				got.res.string_done = unit_ch.string_done;
				got.res.error_flag  = unit_ch.error_flag;
				got.res.unit_count  = unit_ch.unit_count;
				got.last_result     = unit_ch.last_result;
				if (units_due.size() == 0) begin
					mismatches++;
					$display("%0t: expected none, actual cu=%h uv=%b done=%b err=%b cnt=%0d last=%b",
						$realtime, got.res.code_unit, got.res.unit_valid, got.res.string_done,
						got.res.error_flag, got.res.unit_count, got.last_result);
				end else if (got !== units_due[0]) begin
					mismatches++;
					$display("%0t: expected cu=%h uv=%b done=%b err=%b cnt=%0d last=%b, %s",
						$realtime, units_due[0].res.code_unit, units_due[0].res.unit_valid,
						units_due[0].res.string_done, units_due[0].res.error_flag,
						units_due[0].res.unit_count, units_due[0].last_result,
						$sformatf("actual cu=%h uv=%b done=%b err=%b cnt=%0d last=%b",
						got.res.code_unit, got.res.unit_valid, got.res.string_done,
						got.res.error_flag, got.res.unit_count, got.last_result));
					void'(units_due.pop_front());
				end else begin
					void'(units_due.pop_front());
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.byte_valid = 1'b0;
		byte_ch.last       = 1'b0;
		unit_ch.ready      = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.reg_index   = u8u16_pkg::CFG_LF_CONVERT;
		cfg_ch.wr_data     = '0;
		dec  = '0;
		mode = '{lf_convert: 1'b0, error_check: 1'b0, out_capacity: u8u16_pkg::CountMax};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults: plain decoding of every sequence length
		put_item(8'h41, 1'b1, 1'b0);
		put_item(8'h7F, 1'b1, 1'b0);
		put_item(8'hC2, 1'b1, 1'b0);
		put_item(8'hA9, 1'b1, 1'b0);
		put_item(8'hDF, 1'b1, 1'b0);
		put_item(8'hBF, 1'b1, 1'b0);
		put_item(8'hE2, 1'b1, 1'b0);
		put_item(8'h82, 1'b1, 1'b0);
		put_item(8'hAC, 1'b1, 1'b0);
		put_item(8'hF0, 1'b1, 1'b0);
		put_item(8'h9F, 1'b1, 1'b0);
		put_item(8'h98, 1'b1, 1'b0);
		put_item(8'h80, 1'b1, 1'b0);
		put_item(u8u16_pkg::ByteCr, 1'b1, 1'b0);
		put_item(u8u16_pkg::ByteLf, 1'b1, 1'b0);
		// continuation without top bit and zero in continuation slot, unchecked
		put_item(8'hC3, 1'b1, 1'b0);
		put_item(8'h41, 1'b1, 1'b0);
		put_item(8'hC3, 1'b1, 1'b0);
		put_item(8'h00, 1'b1, 1'b0);
		put_item(u8u16_pkg::ByteLf, 1'b1, 1'b1);
		// truncated tail is dropped when unchecked
		put_item(8'hE2, 1'b1, 1'b0);
		put_item(8'h82, 1'b1, 1'b0);
		put_item(8'h00, 1'b0, 1'b1);
		// stray continuation, then bytes ignored until last
		put_item(8'h80, 1'b1, 1'b0);
		put_item(8'hF8, 1'b1, 1'b0);
		put_item(8'h41, 1'b1, 1'b1);
		drain();

		// LF conversion, checking, tiny capacity
		set_mode(1'b1, 1'b1, 17'd2);
		put_item(u8u16_pkg::ByteLf, 1'b1, 1'b0);
		put_item(u8u16_pkg::ByteCr, 1'b1, 1'b0);
		put_item(u8u16_pkg::ByteLf, 1'b1, 1'b0);
		put_item(8'h41, 1'b1, 1'b0);
		put_item(8'h00, 1'b0, 1'b1);
		put_item(8'hC3, 1'b1, 1'b0);
		put_item(8'h41, 1'b1, 1'b0);
		put_item(8'h42, 1'b1, 1'b1);
		put_item(8'hE2, 1'b1, 1'b0);
		put_item(8'h82, 1'b1, 1'b0);
		put_item(8'hFF, 1'b0, 1'b1);
		// zero byte ends early; rest up to last is skipped
		put_item(8'h00, 1'b1, 1'b0);
		put_item(8'h41, 1'b1, 1'b0);
		put_item(8'h55, 1'b0, 1'b0);
		put_item(8'hAA, 1'b0, 1'b1);
		put_item(8'hF4, 1'b1, 1'b0);
		put_item(8'h8F, 1'b1, 1'b0);
		put_item(8'hBF, 1'b1, 1'b0);
		put_item(8'hBF, 1'b1, 1'b1);
		put_item(8'hFF, 1'b1, 1'b0);
		put_item(8'h00, 1'b0, 1'b1);
		drain();

		// random strings across several settings
		random_phase(1'b0, 1'b0, u8u16_pkg::CountMax, 55);
		random_phase(1'b1, 1'b1, 17'd4, 55);

		// back-to-back burst with no gaps and no stalls
		set_mode(1'b0, 1'b0, u8u16_pkg::CountMax);
		steady = 1'b1;
		repeat (24)
			put_item(8'($urandom_range(32, 126)), 1'b1, 1'b0);
		put_item(8'h00, 1'b0, 1'b1);
		drain();
		steady = 1'b0;

		random_phase(1'b1, 1'b0, 17'd0, 55);
		random_phase(1'b0, 1'b1, 17'($urandom_range(1, 40)), 55);

		if (mismatches == 0)
			$display("utf8_to_utf16_decoder_unit: match");
		else
			$display("utf8_to_utf16_decoder_unit: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#30ms;
		$display("utf8_to_utf16_decoder_unit: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/u8u16_pkg.sv
design/u8u16_in_if.sv
design/u8u16_out_if.sv
design/u8u16_cfg_if.sv
design/u8u16_cfg_regs.sv
design/u8u16_decode.sv
design/u8u16_out_buf.sv
design/utf8_to_utf16_decoder_unit.sv
design/u8u16_checker.sv
verif/utf8_to_utf16_decoder_unit_tb.sv
